[rtl/tile_map_column_raycaster_core_defines.svh]
// assertion macros for the raycaster core
`ifndef TILE_MAP_COLUMN_RAYCASTER_CORE_DEFINES_SVH
`define TILE_MAP_COLUMN_RAYCASTER_CORE_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define TMR_CHK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("raycaster check failed");

// next-cycle implication, checked on clk outside reset
`define TMR_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("raycaster check failed");

`endif

[rtl/tmr_pkg.sv]
package tmr_pkg;

  localparam int PADDR_W = 5;
  localparam int DIV_NW  = 20;
  localparam int DIV_DW  = 14;

  localparam logic [14:0] Q_ONE  = 15'd16384;
  localparam logic [14:0] K_C1   = 15'd1184;
  localparam logic [14:0] K_C2   = 15'd10528;
  localparam logic [14:0] K_C3   = 15'd25730;
  localparam logic [12:0] HALF_K = 13'd512;

  typedef enum logic [2:0] {
    REG_POS_X, REG_POS_Y, REG_VIEW, REG_FOV,
    REG_WIDTH, REG_HEIGHT, REG_DEPTH, REG_STEP
  } reg_idx_t;

  typedef enum logic [1:0] {
    T_SIN = 2'd0,
    T_COS = 2'd1,
    T_CF  = 2'd2,
    T_NONE = 2'd3
  } trig_sel_t;

  typedef struct packed {
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [9:0]  view_angle;
    logic [9:0]  fov;
    logic [9:0]  screen_width;
    logic [7:0]  screen_height;
    logic [11:0] max_depth;
    logic [7:0]  step_size;
  } cfg_t;

  typedef struct packed {
    logic        is_cast;
    logic [3:0]  row;
    logic [15:0] bits;
    logic [9:0]  column;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/tmr_ifs.sv]
interface tmr_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [3:0]  row_index;
  logic [15:0] row_bits;
  logic [9:0]  column;
  modport source (output valid, mode, row_index, row_bits, column, input ready);
  modport sink (input valid, mode, row_index, row_bits, column, output ready);
endinterface

interface tmr_out_if;
  logic              valid;
  logic              ready;
  logic [9:0]        column_out;
  logic signed [8:0] ceiling_end;
  logic [8:0]        floor_start;
  logic [1:0]        shade;
  logic              wall_hit;
  modport source (output valid, column_out, ceiling_end, floor_start, shade, wall_hit,
                  input ready);
  modport sink (input valid, column_out, ceiling_end, floor_start, shade, wall_hit,
                output ready);
endinterface

[rtl/tmr_front.sv]
module tmr_front #(
  parameter int MAP_SIZE = 16
) (
  tmr_in_if.sink          in_ch,
  input  tmr_pkg::q_stat_t q_stat,
  output logic            push,
  output tmr_pkg::cmd_t   cmd
);
  import tmr_pkg::*;

  logic keep;

  // loads beyond the map are taken and dropped
  assign keep = in_ch.mode | (int'(in_ch.row_index) < MAP_SIZE);
  assign in_ch.ready = !q_stat.full;
  assign push = in_ch.valid & !q_stat.full & keep;

  always_comb begin
    cmd.is_cast = in_ch.mode;
    cmd.row     = in_ch.row_index;
    cmd.bits    = in_ch.row_bits;
    cmd.column  = in_ch.column;
  end
endmodule

[rtl/tmr_fifo.sv]
module tmr_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tmr_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output tmr_pkg::cmd_t    head,
  output tmr_pkg::q_stat_t stat
);
  import tmr_pkg::*;

  cmd_t       ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign head = ent_r[rp_r];
  assign stat.full = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end
endmodule

[rtl/tmr_div.sv]
module tmr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tmr_pkg::DIV_NW-1:0] dividend,
  input  logic [tmr_pkg::DIV_DW-1:0] divisor,
  output logic                       done,
  output logic [tmr_pkg::DIV_NW-1:0] quotient
);
  import tmr_pkg::*;

  localparam int CW = $clog2(DIV_NW + 1);

  logic [DIV_NW-1:0] num_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [CW-1:0]     cnt_r;
  logic              done_r;
  logic [DIV_DW:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem_r, num_r[DIV_NW-1]};
  assign fits = (rem_sh >= {1'b0, den_r});
  assign done = done_r;
  assign quotient = num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(DIV_NW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // one quotient bit a cycle, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (cnt_r != '0) begin
      num_r <= {num_r[DIV_NW-2:0], fits};
      rem_r <= fits ? DIV_DW'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_DW-1:0];
    end
  end
endmodule

[rtl/tmr_back.sv]
module tmr_back #(
  parameter int MAP_SIZE = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tmr_pkg::cfg_t    cfg,
  input  tmr_pkg::cmd_t    head,
  input  tmr_pkg::q_stat_t q_stat,
  output logic             pop,
  tmr_out_if.source        out_ch
);
  import tmr_pkg::*;

  localparam int AW = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;

  typedef enum logic [10:0] {
    B_IDLE = 11'b00000000001,
    B_ODIV = 11'b00000000010,
    B_TSET = 11'b00000000100,
    B_TMUL = 11'b00000001000,
    B_PREP = 11'b00000010000,
    B_MRD  = 11'b00000100000,
    B_MCHK = 11'b00001000000,
    B_CORR = 11'b00010000000,
    B_CNUM = 11'b00100000000,
    B_CDIV = 11'b01000000000,
    B_DONE = 11'b10000000000
  } bstate_t;

  bstate_t state_r;

  logic [15:0]        mem_r [MAP_SIZE];
  logic [MAP_SIZE-1:0] vld_r;
  logic [15:0]        rd_r;
  logic               rdv_r;

  logic [9:0]         col_r;
  logic [9:0]         offs_r;
  trig_sel_t          tsel_r;
  logic [1:0]         stg_r;
  logic               neg_r;
  logic [14:0]        t_r, t2_r, a_r;
  logic signed [15:0] sn_r, cs_r, cf_r;
  logic signed [29:0] accx_r, accy_r, dcx_r, dcy_r;
  logic [12:0]        dist_r;
  logic [7:0]         cx_r;
  logic               wall_r;
  logic [12:0]        cc_r;
  logic               nneg_r;
  logic [1:0]         shade_r;
  logic signed [8:0]  ceil_r;

  logic               ov_r;
  logic [9:0]         o_col_r;
  logic signed [8:0]  o_ceil_r;
  logic [8:0]         o_floor_r;
  logic [1:0]         o_shade_r;
  logic               o_wall_r;

  logic [7:0]         step_w;
  logic [9:0]         width_w;
  logic [9:0]         ray_w, ang_w;
  logic [1:0]         qd_w;
  logic [13:0]        f_w;
  logic [14:0]        t_w;
  logic [14:0]        mul_a, mul_b;
  logic [29:0]        prod_w;
  logic [14:0]        pr15, v_w;
  logic signed [15:0] sv_w;
  logic signed [24:0] dcx_w, dcy_w;
  logic [7:0]         cx_w, cy_w;
  logic               oob_w, dlt_w, hit_w;
  logic [AW-1:0]      cy_a;
  logic signed [29:0] cp_w, corr_w;
  logic [12:0]        mag_w;
  logic [19:0]        colfov_w, num_w;
  logic [15:0]        c5_w;
  logic [15:0]        md_w;
  logic               div_start, div_done;
  logic [DIV_NW-1:0]  div_num, div_q;
  logic [DIV_DW-1:0]  div_den;
  logic signed [8:0]  ceil_w;

  assign step_w  = (cfg.step_size == 8'd0) ? 8'd1 : cfg.step_size;
  assign width_w = (cfg.screen_width == 10'd0) ? 10'd1 : cfg.screen_width;
  assign pop = (state_r == B_IDLE) && !q_stat.empty;

  // trig operand set up
  assign ray_w = cfg.view_angle + offs_r;
  assign ang_w = (tsel_r == T_CF) ? offs_r : ray_w;
  assign qd_w  = ang_w[9:8] + ((tsel_r == T_SIN) ? 2'd0 : 2'd1);
  assign f_w   = {ang_w[7:0], 6'd0};
  assign t_w   = qd_w[0] ? (Q_ONE - {1'b0, f_w}) : {1'b0, f_w};

  always_comb begin
    case (stg_r)
      2'd0:    begin mul_a = t_r;        mul_b = t_r;  end
      2'd1:    begin mul_a = K_C1;       mul_b = t2_r; end
      2'd2:    begin mul_a = K_C2 - a_r; mul_b = t2_r; end
      default: begin mul_a = K_C3 - a_r; mul_b = t_r;  end
    endcase
  end
  assign prod_w = mul_a * mul_b;
  assign pr15   = prod_w[28:14];
  assign v_w    = (pr15 > Q_ONE) ? Q_ONE : pr15;
  assign sv_w   = neg_r ? -$signed({1'b0, v_w}) : $signed({1'b0, v_w});

  assign dcx_w = cs_r * $signed({1'b0, step_w});
  assign dcy_w = sn_r * $signed({1'b0, step_w});

  // march sample
  assign cx_w  = accx_r[29:22];
  assign cy_w  = accy_r[29:22];
  assign oob_w = cx_w[7] | cy_w[7] | (int'(cx_w[6:0]) >= MAP_SIZE)
               | (int'(cy_w[6:0]) >= MAP_SIZE);
  assign dlt_w = dist_r < {1'b0, cfg.max_depth};
  assign cy_a  = AW'(cy_w[6:0]);
  assign hit_w = rdv_r & (cx_r[6:4] == 3'd0) & rd_r[cx_r[3:0]];

  assign cp_w   = $signed({1'b0, dist_r}) * cf_r;
  assign corr_w = cp_w >>> 14;

  assign mag_w    = (cc_r < HALF_K) ? (HALF_K - cc_r) : (cc_r - HALF_K);
  assign num_w    = cfg.screen_height * mag_w[11:0];
  assign colfov_w = head.column * cfg.fov;
  assign c5_w     = cc_r * 3'd5;
  assign md_w     = {4'd0, cfg.max_depth};

  assign div_start = pop & head.is_cast | (state_r == B_CNUM);
  assign div_num   = (state_r == B_CNUM) ? num_w : colfov_w;
  assign div_den   = (state_r == B_CNUM) ? {cc_r, 1'b0} : {4'd0, width_w};

  tmr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    if (nneg_r) begin
      ceil_w = (div_q == '0) ? 9'sd0 : -9'sd1;
    end else if (div_q > {12'd0, cfg.screen_height}) begin
      ceil_w = $signed({1'b0, cfg.screen_height});
    end else begin
      ceil_w = $signed(div_q[8:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      vld_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (pop && !head.is_cast) begin
        vld_r[AW'(head.row)] <= 1'b1;
      end
      if (state_r == B_DONE && (!ov_r || out_ch.ready)) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: if (pop && head.is_cast) begin
          state_r <= B_ODIV;
        end
        B_ODIV: if (div_done) begin
          state_r <= B_TSET;
        end
        B_TSET: state_r <= B_TMUL;
        B_TMUL: if (stg_r == 2'd3) begin
          state_r <= (tsel_r == T_CF) ? B_PREP : B_TSET;
        end
        B_PREP: state_r <= B_MRD;
        B_MRD:  state_r <= (!dlt_w || oob_w) ? B_CORR : B_MCHK;
        B_MCHK: state_r <= hit_w ? B_CORR : B_MRD;
        B_CORR: state_r <= B_CNUM;
        B_CNUM: state_r <= B_CDIV;
        B_CDIV: if (div_done) begin
          state_r <= B_DONE;
        end
        B_DONE: if (!ov_r || out_ch.ready) begin
          state_r <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !head.is_cast) begin
      mem_r[AW'(head.row)] <= head.bits;
    end
    if (state_r == B_MRD) begin
      rd_r  <= mem_r[cy_a];
      rdv_r <= vld_r[cy_a];
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        col_r <= head.column;
      end
      B_ODIV: begin
        offs_r <= div_q[9:0] - {1'b0, cfg.fov[9:1]};
        tsel_r <= T_SIN;
      end
      B_TSET: begin
        t_r   <= t_w;
        neg_r <= qd_w[1];
        stg_r <= 2'd0;
      end
      B_TMUL: begin
        stg_r <= stg_r + 2'd1;
        case (stg_r)
          2'd0: t2_r <= pr15;
          2'd1, 2'd2: a_r <= pr15;
          default: begin
            case (tsel_r)
              T_SIN:   sn_r <= sv_w;
              T_COS:   cs_r <= sv_w;
              default: cf_r <= sv_w;
            endcase
            tsel_r <= trig_sel_t'(tsel_r + 2'd1);
          end
        endcase
      end
      B_PREP: begin
        accx_r <= $signed({4'd0, cfg.pos_x, 14'd0});
        accy_r <= $signed({4'd0, cfg.pos_y, 14'd0});
        dcx_r  <= 30'(dcx_w);
        dcy_r  <= 30'(dcy_w);
        dist_r <= '0;
        wall_r <= 1'b0;
      end
      B_MRD: begin
        cx_r <= cx_w;
        if (dlt_w && oob_w) begin
          dist_r <= {1'b0, cfg.max_depth} + {5'd0, step_w};
        end
      end
      B_MCHK: begin
        dist_r <= dist_r + {5'd0, step_w};
        if (hit_w) begin
          wall_r <= 1'b1;
        end else begin
          accx_r <= accx_r + dcx_r;
          accy_r <= accy_r + dcy_r;
        end
      end
      B_CORR: begin
        cc_r   <= (corr_w < 30'sd1) ? 13'd1 : corr_w[12:0];
      end
      B_CNUM: begin
        nneg_r <= cc_r < HALF_K;
        if (c5_w <= md_w) begin
          shade_r <= 2'd0;
        end else if (c5_w <= {md_w[14:0], 1'b0}) begin
          shade_r <= 2'd1;
        end else if (c5_w <= {md_w[13:0], 2'b0}) begin
          shade_r <= 2'd2;
        end else begin
          shade_r <= 2'd3;
        end
      end
      B_CDIV: begin
        ceil_r <= ceil_w;
      end
      default: begin
      end
    endcase
  end

  // nneg_r is settled in B_CNUM, ahead of the divider result
  always_ff @(posedge clk) begin
    if (state_r == B_DONE && (!ov_r || out_ch.ready)) begin
      o_col_r   <= col_r;
      o_ceil_r  <= ceil_r;
      o_floor_r <= {1'b0, cfg.screen_height} - $unsigned(ceil_r);
      o_shade_r <= shade_r;
      o_wall_r  <= wall_r;
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.column_out  = o_col_r;
  assign out_ch.ceiling_end = o_ceil_r;
  assign out_ch.floor_start = o_floor_r;
  assign out_ch.shade       = o_shade_r;
  assign out_ch.wall_hit    = o_wall_r;
endmodule

[rtl/tile_map_column_raycaster_core.sv]
// channel | dir | words
// in_ch   | in  | mode, row_index, row_bits, column (valid/ready)
// out_ch  | out | column_out, ceiling_end, floor_start, shade, wall_hit
// apb     | in  | eight registers at 4*i, pready tied high
// a load word is written into the map when it is popped and gives no result
// a cast runs two divisions and 3 sine passes, then a march in which each step
// reads the map row into a register before it is checked
// a two-word queue lets input words be taken while a cast is marching
// rst_n is synchronous; the wall map reads as empty until each row is written
`include "tile_map_column_raycaster_core_defines.svh"
module tile_map_column_raycaster_core #(
  parameter int MAP_SIZE = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  tmr_in_if.sink                       in_ch,
  tmr_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tmr_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import tmr_pkg::*;

  cfg_t     cfg_r;
  cmd_t     f_cmd, q_head;
  q_stat_t  q_st;
  logic     q_push, q_pop;
  reg_idx_t idx;
  logic [8:0] floor_chk;

  assign pready = 1'b1;
  assign idx = reg_idx_t'(paddr[4:2]);
  assign floor_chk = {1'b0, cfg_r.screen_height} - $unsigned(out_ch.ceiling_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_x         <= 12'd1792;
      cfg_r.pos_y         <= 12'd2048;
      cfg_r.view_angle    <= 10'd326;
      cfg_r.fov           <= 10'd256;
      cfg_r.screen_width  <= 10'd80;
      cfg_r.screen_height <= 8'd24;
      cfg_r.max_depth     <= 12'd3840;
      cfg_r.step_size     <= 8'd26;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_POS_X:  cfg_r.pos_x         <= pwdata[11:0];
        REG_POS_Y:  cfg_r.pos_y         <= pwdata[11:0];
        REG_VIEW:   cfg_r.view_angle    <= pwdata[9:0];
        REG_FOV:    cfg_r.fov           <= pwdata[9:0];
        REG_WIDTH:  cfg_r.screen_width  <= pwdata[9:0];
        REG_HEIGHT: cfg_r.screen_height <= pwdata[7:0];
        REG_DEPTH:  cfg_r.max_depth     <= pwdata[11:0];
        REG_STEP:   cfg_r.step_size     <= pwdata[7:0];
        default:    cfg_r.step_size     <= cfg_r.step_size;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_POS_X:  prdata = {20'd0, cfg_r.pos_x};
      REG_POS_Y:  prdata = {20'd0, cfg_r.pos_y};
      REG_VIEW:   prdata = {22'd0, cfg_r.view_angle};
      REG_FOV:    prdata = {22'd0, cfg_r.fov};
      REG_WIDTH:  prdata = {22'd0, cfg_r.screen_width};
      REG_HEIGHT: prdata = {24'd0, cfg_r.screen_height};
      REG_DEPTH:  prdata = {20'd0, cfg_r.max_depth};
      REG_STEP:   prdata = {24'd0, cfg_r.step_size};
      default:    prdata = '0;
    endcase
  end

  tmr_front #(.MAP_SIZE(MAP_SIZE)) u_front (
    .in_ch  (in_ch),
    .q_stat (q_st),
    .push   (q_push),
    .cmd    (f_cmd)
  );

  tmr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (f_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_st)
  );

  tmr_back #(.MAP_SIZE(MAP_SIZE)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .head   (q_head),
    .q_stat (q_st),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

  `TMR_CHK_NOW(a_floor_sum, out_ch.valid, out_ch.floor_start == floor_chk)
  `TMR_CHK_NOW(a_ceil_sat, out_ch.valid && out_ch.ceiling_end[8], out_ch.ceiling_end == -9'sd1)
  `TMR_CHK_NEXT(a_full_holds, q_st.full && !q_pop, !in_ch.ready)
endmodule

[bench/tb_tile_map_column_raycaster_core.sv]
`timescale 1ns / 100ps
module tb_tile_map_column_raycaster_core;
  import tmr_pkg::*;

  localparam int LIMIT = 4000000;
  localparam int DRAIN = 200;

  typedef struct {
    logic [9:0]        col;
    logic signed [8:0] ceil_end;
    logic [8:0]        floor_start;
    logic [1:0]        shade;
    logic              wall;
  } column_res_t;

  class column_scoreboard;
    cfg_t          cfg;
    logic [15:0]   wall_rows [16];
    column_res_t   pending_cols [$];
    int            errors;
    int            casts;
    int            hits;
    int            checked;

    function new();
      errors = 0; casts = 0; hits = 0; checked = 0;
      foreach (wall_rows[i]) wall_rows[i] = '0;
      cfg = '{pos_x: 12'd1792, pos_y: 12'd2048, view_angle: 10'd326, fov: 10'd256,
              screen_width: 10'd80, screen_height: 8'd24, max_depth: 12'd3840,
              step_size: 8'd26};
    endfunction

    function int quarter_wave(int unsigned t);
      int unsigned t2, inner, mid, v;
      t2 = (t * t) >> 14;
      inner = (32'd1184 * t2) >> 14;
      mid = ((32'd10528 - inner) * t2) >> 14;
      v = ((32'd25730 - mid) * t) >> 14;
      if (v > 16384) v = 16384;
      return int'(v);
    endfunction

    function int sine_at(int unsigned ph);
      int unsigned quad, f;
      int v;
      ph = ph & 32'hFFFF;
      quad = ph >> 14;
      f = ph & 32'h3FFF;
      if (quad[0]) f = 16384 - f;
      v = quarter_wave(f);
      return quad[1] ? -v : v;
    endfunction

    function int unsigned phase_at(longint a);
      longint m;
      m = a % 1024;
      if (m < 0) m += 1024;
      return int'((m << 16) / 1024);
    endfunction

    function void note(cmd_t c);
      int unsigned w, stp, ray_len, ph;
      longint offs, cx, cy, corr, num, den, ce, c5, md;
      int sn, cs, cf;
      bit stop, wall;
      column_res_t r;
      if (!c.is_cast) begin
        wall_rows[c.row] = c.bits;
        return;
      end
      w = cfg.screen_width != 0 ? cfg.screen_width : 1;
      stp = cfg.step_size != 0 ? cfg.step_size : 1;
      offs = longint'((int'(c.column) * int'(cfg.fov)) / w) - longint'(cfg.fov / 2);
      ph = phase_at(longint'(cfg.view_angle) + offs);
      sn = sine_at(ph);
      cs = sine_at(ph + 16384);
      ray_len = 0; stop = 0; wall = 0;
      while (!stop && ray_len < cfg.max_depth) begin
        cx = (longint'(cfg.pos_x) * 16384 + longint'(cs) * longint'(ray_len)) >>> 22;
        cy = (longint'(cfg.pos_y) * 16384 + longint'(sn) * longint'(ray_len)) >>> 22;
        if (cx < 0 || cx > 15 || cy < 0 || cy > 15) begin
          ray_len = cfg.max_depth;
          stop = 1;
        end else if (wall_rows[cy][cx]) begin
          stop = 1;
          wall = 1;
        end
        ray_len += stp;
      end
      cf = sine_at(phase_at(offs) + 16384);
      corr = (longint'(ray_len) * longint'(cf)) >>> 14;
      if (corr < 1) corr = 1;
      num = longint'(cfg.screen_height) * (corr - 512);
      den = 2 * corr;
      ce = num / den;
      if (ce < -1) ce = -1;
      if (ce > longint'(cfg.screen_height)) ce = longint'(cfg.screen_height);
      c5 = corr * 5;
      md = cfg.max_depth;
      r.col = c.column;
      r.ceil_end = ce[8:0];
      r.floor_start = 9'(longint'(cfg.screen_height) - ce);
      r.shade = c5 <= md ? 2'd0 : c5 <= 2 * md ? 2'd1 : c5 <= 4 * md ? 2'd2 : 2'd3;
      r.wall = wall;
      casts++;
      if (wall) hits++;
      pending_cols.push_back(r);
    endfunction

    function void check(column_res_t a);
      column_res_t e;
      if (pending_cols.size() == 0) begin
        $display("%0t: unexpected word col %0d", $time, a.col);
        errors++;
        return;
      end
      e = pending_cols.pop_front();
      checked++;
      if (a.col !== e.col) begin
        $display("%0t: column exp %0d got %0d", $time, e.col, a.col); errors++;
      end
      if (a.ceil_end !== e.ceil_end) begin
        $display("%0t: ceiling_end exp %0d got %0d", $time, e.ceil_end, a.ceil_end);
        errors++;
      end
      if (a.floor_start !== e.floor_start) begin
        $display("%0t: floor_start exp %0d got %0d", $time, e.floor_start, a.floor_start);
        errors++;
      end
      if (a.shade !== e.shade) begin
        $display("%0t: shade exp %0d got %0d", $time, e.shade, a.shade); errors++;
      end
      if (a.wall !== e.wall) begin
        $display("%0t: wall_hit exp %0d got %0d", $time, e.wall, a.wall); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  tmr_in_if in_ch ();
  tmr_out_if out_ch ();

  tile_map_column_raycaster_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  column_scoreboard sb;
  bit quiet;
  bit hold_req;
  int hold_left;
  int cycles;
  int words_sent;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side, with an occasional long hold-off
  initial begin
    column_res_t a;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        a.col = out_ch.column_out;
        a.ceil_end = out_ch.ceiling_end;
        a.floor_start = out_ch.floor_start;
        a.shade = out_ch.shade;
        a.wall = out_ch.wall_hit;
        sb.check(a);
      end
      if (hold_req) begin
        hold_left = 3000;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= rst_n && (quiet || $urandom_range(99) >= 14);
      end
    end
  end

  task automatic send_word(cmd_t c);
    in_ch.valid <= 1'b1;
    in_ch.mode <= c.is_cast;
    in_ch.row_index <= c.row;
    in_ch.row_bits <= c.bits;
    in_ch.column <= c.column;
    do @(posedge clk); while (!in_ch.ready);
    sb.note(c);
    words_sent++;
    if (!quiet && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_cols.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, int unsigned v);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {r, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    case (r)
      REG_POS_X:  sb.cfg.pos_x = v[11:0];
      REG_POS_Y:  sb.cfg.pos_y = v[11:0];
      REG_VIEW:   sb.cfg.view_angle = v[9:0];
      REG_FOV:    sb.cfg.fov = v[9:0];
      REG_WIDTH:  sb.cfg.screen_width = v[9:0];
      REG_HEIGHT: sb.cfg.screen_height = v[7:0];
      REG_DEPTH:  sb.cfg.max_depth = v[11:0];
      default:    sb.cfg.step_size = v[7:0];
    endcase
  endtask

  task automatic set_all(int unsigned px, int unsigned py, int unsigned va, int unsigned fv,
                         int unsigned sw, int unsigned sh, int unsigned md, int unsigned st);
    write_reg(REG_POS_X, px); write_reg(REG_POS_Y, py);
    write_reg(REG_VIEW, va);  write_reg(REG_FOV, fv);
    write_reg(REG_WIDTH, sw); write_reg(REG_HEIGHT, sh);
    write_reg(REG_DEPTH, md); write_reg(REG_STEP, st);
  endtask

  function automatic cmd_t load_word(int unsigned r, int unsigned b);
    cmd_t c;
    c.is_cast = 1'b0; c.row = r[3:0]; c.bits = b[15:0]; c.column = 10'($urandom);
    return c;
  endfunction

  function automatic cmd_t cast_word(int unsigned col);
    cmd_t c;
    c.is_cast = 1'b1; c.row = 4'($urandom); c.bits = 16'($urandom); c.column = col[9:0];
    return c;
  endfunction

  task automatic random_words(int n);
    int unsigned b, w;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 30) begin
        b = $urandom_range(2) == 0 ? $urandom : ($urandom & $urandom & $urandom);
        send_word(load_word($urandom_range(15), b));
      end else begin
        w = sb.cfg.screen_width;
        send_word(cast_word($urandom_range(9) == 0 ? $urandom_range(1023)
                                                   : $urandom_range(w)));
      end
    end
  endtask

  initial begin
    sb = new();
    clk = 0; rst_n = 0; cycles = 0; words_sent = 0;
    quiet = 0; hold_req = 0; hold_left = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_ch.valid = 0; in_ch.mode = 0; in_ch.row_index = '0; in_ch.row_bits = '0;
    in_ch.column = '0; out_ch.ready = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty map, then a walled room
    send_word(cast_word(0));
    send_word(cast_word(79));
    send_word(load_word(0, 16'hFFFF));
    send_word(load_word(15, 16'hFFFF));
    for (int r = 1; r < 15; r++) send_word(load_word(r, 16'h8001));
    send_word(load_word(6, 16'h0000));
    send_word(cast_word(0));
    send_word(cast_word(40));
    send_word(cast_word(79));
    send_word(cast_word(80));
    send_word(cast_word(1023));
    send_word(load_word(6, 16'h8001));
    settle();

    // corner positions, widest and narrowest view and screen
    set_all(0, 0, 1023, 1023, 1, 255, 4095, 255);
    random_words(90);
    settle();
    set_all(4095, 4095, 0, 1, 1023, 1, 1, 1);
    random_words(90);
    settle();
    // zero width and zero step are taken as one; a zero fov is used as it stands
    set_all(1792, 2048, 512, 0, 0, 24, 200, 0);
    random_words(60);
    settle();
    // finest step at full depth, slow so kept short
    set_all(2000, 1000, 256, 256, 80, 24, 4095, 1);
    for (int i = 0; i < 6; i++) send_word(cast_word($urandom_range(80)));
    settle();

    // receiver held off while the sender keeps offering
    set_all(1792, 2048, 326, 256, 80, 24, 3840, 26);
    hold_req = 1;
    random_words(120);
    settle();

    quiet = 1;
    set_all($urandom_range(4095), $urandom_range(4095), $urandom_range(1023),
            $urandom_range(1, 1023), $urandom_range(1, 1023), $urandom_range(1, 255),
            $urandom_range(1, 4095), $urandom_range(16, 255));
    random_words(120);
    settle();
    quiet = 0;

    for (int p = 0; p < 4; p++) begin
      set_all($urandom_range(4095), $urandom_range(4095), $urandom_range(1023),
              $urandom_range(1, 1023), $urandom_range(1, 1023), $urandom_range(1, 255),
              $urandom_range(1, 4095), $urandom_range(10, 255));
      random_words(110);
      settle();
    end

    $display("sent %0d words, %0d casts checked, %0d struck walls",
             words_sent, sb.checked, sb.hits);
    $display("configuration extremes, zero width and step, long output stall covered");
    if (sb.errors == 0 && sb.pending_cols.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
